>>> rtl/salc_pkg.sv
// Shared constants, types and helper functions of the LRU write-back cache.
`default_nettype none
package salc_pkg;

  localparam int NUM_SETS       = 16;
  localparam int NUM_WAYS       = 4;
  localparam int WORDS_PER_LINE = 4;
  localparam int ADDR_BITS      = 16;

  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int WAY_W      = $clog2(NUM_WAYS);
  localparam int OFFS_W     = $clog2(WORDS_PER_LINE);
  localparam int WORD_W     = ADDR_BITS - 2;
  localparam int TAG_W      = WORD_W - OFFS_W - SET_W;
  localparam int LINE_W     = SET_W + WAY_W;
  localparam int NUM_LINES  = NUM_SETS * NUM_WAYS;
  localparam int DATA_DEPTH = NUM_LINES * WORDS_PER_LINE;
  localparam int BACK_DEPTH = 1 << WORD_W;
  localparam int ROW_W      = NUM_WAYS * TAG_W;
  localparam int CNT_W      = OFFS_W + 1;
  localparam int DATA_W     = 32;
  localparam int STAT_W     = 32;
  localparam int DIRTY_W    = 7;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [WAY_W-1:0] way_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic decide;
    logic wb_step;
    logic fill_step;
    logic access;
    logic load_out;
  } salc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic accepted;
    logic clr_last;
    logic need_wb;
    logic need_fill;
    logic fill_pending;
    logic step_last;
    logic out_free;
  } salc_sts_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

>>> rtl/salc_if.sv
// Request and response channel interfaces of the cache.
`default_nettype none
interface salc_req_if import salc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [ADDR_BITS-1:0]        addr;
  logic signed [DATA_W-1:0]    wr_data;

  modport source(output valid, cmd, addr, wr_data, input ready);
  modport sink(input valid, cmd, addr, wr_data, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        wrote_back;
  logic                        filled;
  logic signed [DATA_W-1:0]    read_data;
  logic [STAT_W-1:0]           hit_count;
  logic [STAT_W-1:0]           miss_count;
  logic [STAT_W-1:0]           mem_access_count;
  logic [DIRTY_W-1:0]          dirty_lines;

  modport source(output valid, hit, wrote_back, filled, read_data, hit_count, miss_count,
                 mem_access_count, dirty_lines, input ready);
  modport sink(input valid, hit, wrote_back, filled, read_data, hit_count, miss_count,
               mem_access_count, dirty_lines, output ready);
endinterface
`default_nettype wire

>>> rtl/salc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/salc_ctrl.sv
// Sequencing state machine of the cache.
`default_nettype none
module salc_ctrl import salc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire salc_sts_t  sts,
  output salc_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_WB,
    S_FILL,
    S_ACCESS,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:  if (sts.clr_last) state <= S_IDLE;
        S_IDLE:   if (sts.accepted) state <= S_LOOKUP;
        S_LOOKUP: begin
          if (sts.need_wb) state <= S_WB;
          else if (sts.need_fill) state <= S_FILL;
          else state <= S_ACCESS;
        end
        S_WB: begin
          if (sts.step_last) state <= sts.fill_pending ? S_FILL : S_ACCESS;
        end
        S_FILL:   if (sts.step_last) state <= S_ACCESS;
        S_ACCESS: state <= S_RESP;
        S_RESP:   if (sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.in_ready  = (state == S_IDLE);
    cmd.clr_step  = (state == S_CLEAR);
    cmd.decide    = (state == S_LOOKUP);
    cmd.wb_step   = (state == S_WB);
    cmd.fill_step = (state == S_FILL);
    cmd.access    = (state == S_ACCESS);
    cmd.load_out  = (state == S_RESP) && sts.out_free;
  end

endmodule
`default_nettype wire

>>> rtl/salc_dp.sv
// Datapath of the cache: tag, line and backing memories, LRU state and statistics.
`default_nettype none
module salc_dp import salc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  salc_req_if.sink       req,
  salc_rsp_if.source     rsp,
  input  wire salc_cmd_t cmd,
  output salc_sts_t      sts
);

  // Latched request
  logic                    is_write;
  logic [SET_W-1:0]        set_q;
  logic [TAG_W-1:0]        tag_q;
  logic [OFFS_W-1:0]       offs_q;
  logic [DATA_W-1:0]       wdata_q;
  // Lookup outcome
  way_t                    way_q;
  logic                    hit_q;
  logic                    wb_q;
  logic                    fill_q;
  logic [TAG_W-1:0]        vtag_q;
  logic [ROW_W-1:0]        row_q;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_prev;
  logic [WORD_W-1:0]       clr_addr;
  // Line state, one row of ways per set
  logic [NUM_WAYS-1:0]            valid [NUM_SETS];
  logic [NUM_WAYS-1:0]            dirty [NUM_SETS];
  logic [NUM_WAYS-1:0][WAY_W-1:0] rank  [NUM_SETS];
  logic [STAT_W-1:0]       hit_total;
  logic [STAT_W-1:0]       miss_total;
  logic [STAT_W-1:0]       mem_total;
  logic [DIRTY_W-1:0]      dirty_total;
  logic                    out_valid;

  logic                    accepted;
  logic [WORD_W-1:0]       in_word;
  logic [ROW_W-1:0]        tag_rdata;
  logic [DATA_W-1:0]       data_rdata;
  logic [DATA_W-1:0]       back_rdata;

  logic                    tag_en, tag_we;
  logic [SET_W-1:0]        tag_addr;
  logic [ROW_W-1:0]        tag_wdata;
  logic                    data_en, data_we;
  logic [LINE_W+OFFS_W-1:0] data_addr;
  logic [DATA_W-1:0]       data_wdata;
  logic                    back_en, back_we;
  logic [WORD_W-1:0]       back_addr;
  logic [DATA_W-1:0]       back_wdata;

  logic                    hit_c, free_c, need_wb_c, need_fill_c;
  way_t                    hit_way, free_way, vic_way, way_c;
  way_t                    best;
  logic                    in_step;
  logic [LINE_W-1:0]       ln_q;
  logic [STAT_W-1:0]       mem_wb;

  assign accepted  = req.valid && cmd.in_ready;
  assign req.ready = cmd.in_ready;
  assign in_word   = req.addr[ADDR_BITS-1:2];
  assign in_step   = (cnt < CNT_W'(WORDS_PER_LINE));
  assign cnt_prev  = cnt - 1'b1;
  assign ln_q      = {set_q, way_q};

  // Hit search, lowest free way and LRU victim over the set's ways
  always_comb begin
    hit_c    = 1'b0;
    free_c   = 1'b0;
    hit_way  = '0;
    free_way = '0;
    vic_way  = '0;
    best     = '0;
    for (int v = 0; v < NUM_WAYS; v++) begin
      if (!hit_c && valid[set_q][v] && tag_rdata[v*TAG_W +: TAG_W] == tag_q) begin
        hit_c   = 1'b1;
        hit_way = way_t'(v);
      end
      if (!valid[set_q][v] && !free_c) begin
        free_c   = 1'b1;
        free_way = way_t'(v);
      end
      if (rank[set_q][v] > best) begin
        best    = rank[set_q][v];
        vic_way = way_t'(v);
      end
    end
    way_c       = hit_c ? hit_way : (free_c ? free_way : vic_way);
    need_wb_c   = !hit_c && !free_c && dirty[set_q][vic_way];
    need_fill_c = !hit_c && (is_write != CMD_WRITE || WORDS_PER_LINE != 1);
  end

  always_comb begin
    sts              = '0;
    sts.accepted     = accepted;
    sts.clr_last     = (clr_addr == '1);
    sts.need_wb      = need_wb_c;
    sts.need_fill    = need_fill_c;
    sts.fill_pending = fill_q;
    sts.step_last    = (cnt == CNT_W'(WORDS_PER_LINE));
    sts.out_free     = !out_valid || rsp.ready;
  end

  // Memory port steering
  always_comb begin
    tag_en   = accepted || cmd.access;
    tag_we   = cmd.access;
    tag_addr = cmd.access ? set_q : in_word[OFFS_W +: SET_W];
    tag_wdata = row_q;
    tag_wdata[way_q*TAG_W +: TAG_W] = tag_q;

    data_en    = 1'b0;
    data_we    = 1'b0;
    data_addr  = {ln_q, cnt[OFFS_W-1:0]};
    data_wdata = back_rdata;
    if (cmd.wb_step && in_step) begin
      data_en = 1'b1;
    end else if (cmd.fill_step && cnt != '0) begin
      data_en   = 1'b1;
      data_we   = 1'b1;
      data_addr = {ln_q, cnt_prev[OFFS_W-1:0]};
    end else if (cmd.access) begin
      data_en    = 1'b1;
      data_we    = is_write;
      data_addr  = {ln_q, offs_q};
      data_wdata = wdata_q;
    end

    back_en    = 1'b0;
    back_we    = 1'b0;
    back_addr  = {tag_q, set_q, cnt[OFFS_W-1:0]};
    back_wdata = data_rdata;
    if (cmd.clr_step) begin
      back_en    = 1'b1;
      back_we    = 1'b1;
      back_addr  = clr_addr;
      back_wdata = '0;
    end else if (cmd.wb_step && cnt != '0) begin
      back_en   = 1'b1;
      back_we   = 1'b1;
      back_addr = {vtag_q, set_q, cnt_prev[OFFS_W-1:0]};
    end else if (cmd.fill_step && in_step) begin
      back_en = 1'b1;
    end
  end

  salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk, .en(tag_en), .we(tag_we), .addr(tag_addr), .wdata(tag_wdata), .rdata(tag_rdata)
  );

  salc_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk, .en(data_en), .we(data_we), .addr(data_addr), .wdata(data_wdata),
    .rdata(data_rdata)
  );

  salc_ram #(.WIDTH(DATA_W), .DEPTH(BACK_DEPTH)) u_back_ram (
    .clk, .en(back_en), .we(back_we), .addr(back_addr), .wdata(back_wdata),
    .rdata(back_rdata)
  );

  assign mem_wb = wb_q ? sat_inc(mem_total) : mem_total;

  // Payload registers
  always_ff @(posedge clk) begin
    if (accepted) begin
      is_write <= req.cmd;
      offs_q   <= in_word[OFFS_W-1:0];
      set_q    <= in_word[OFFS_W +: SET_W];
      tag_q    <= in_word[WORD_W-1 -: TAG_W];
      wdata_q  <= req.wr_data;
    end
    if (cmd.decide) begin
      way_q  <= way_c;
      vtag_q <= tag_rdata[vic_way*TAG_W +: TAG_W];
      row_q  <= tag_rdata;
    end
    if (cmd.load_out) begin
      rsp.hit              <= hit_q;
      rsp.wrote_back       <= wb_q;
      rsp.filled           <= fill_q;
      rsp.read_data        <= (is_write == CMD_WRITE) ? wdata_q : data_rdata;
      rsp.hit_count        <= hit_total;
      rsp.miss_count       <= miss_total;
      rsp.mem_access_count <= mem_total;
      rsp.dirty_lines      <= dirty_total;
    end
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      cnt         <= '0;
      hit_q       <= 1'b0;
      wb_q        <= 1'b0;
      fill_q      <= 1'b0;
      hit_total   <= '0;
      miss_total  <= '0;
      mem_total   <= '0;
      dirty_total <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_SETS; i++) begin
        valid[i] <= '0;
        dirty[i] <= '0;
        rank[i]  <= '0;
      end
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.decide) begin
        hit_q  <= hit_c;
        wb_q   <= need_wb_c;
        fill_q <= need_fill_c;
        cnt    <= '0;
      end
      if (cmd.wb_step || cmd.fill_step) begin
        cnt <= sts.step_last ? '0 : cnt + 1'b1;
      end
      if (cmd.access) begin
        // Age the ways that were more recent than the touched one
        for (int v = 0; v < NUM_WAYS; v++) begin
          if (way_t'(v) != way_q && valid[set_q][v] &&
              (!valid[set_q][way_q] || rank[set_q][v] < rank[set_q][way_q]) &&
              rank[set_q][v] != way_t'(NUM_WAYS - 1)) begin
            rank[set_q][v] <= rank[set_q][v] + 1'b1;
          end
        end
        rank[set_q][way_q]  <= '0;
        valid[set_q][way_q] <= 1'b1;
        dirty[set_q][way_q] <= (is_write == CMD_WRITE) || (hit_q && dirty[set_q][way_q]);
        if (hit_q) hit_total <= sat_inc(hit_total);
        else miss_total <= sat_inc(miss_total);
        mem_total <= fill_q ? sat_inc(mem_wb) : mem_wb;
        dirty_total <= dirty_total - DIRTY_W'(wb_q) +
                       DIRTY_W'((is_write == CMD_WRITE) && !(hit_q && dirty[set_q][way_q]));
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

>>> rtl/set_assoc_lru_writeback_cache.sv
// Sequence: after accept, a lookup; on a miss a writeback of the LRU victim line if it
// is dirty and a fill of the line; then the access and the result load.
// One item at a time; the next is taken the cycle after the result loads, the pace
// set by the single-port line and backing memories moving one word per cycle. A stalled
// result holds the cache in its response state, and no new item is taken meanwhile.
// Reset: synchronous; the backing store is then swept to zero, and no request is taken
// until the sweep is done.
`default_nettype none
module set_assoc_lru_writeback_cache import salc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  salc_req_if.sink   req,
  salc_rsp_if.source rsp
);

  salc_cmd_t cmd;
  salc_sts_t sts;

  salc_ctrl u_ctrl (
    .clk, .rst, .sts, .cmd
  );

  salc_dp u_dp (
    .clk, .rst, .req, .rsp, .cmd, .sts
  );

endmodule
`default_nettype wire

>>> sim/tb_salc_if.sv
// Testbench package: the result record shared by the predictor and the checker.
`timescale 1ns / 1ps
package tb_salc_pkg;
  import salc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              wrote_back;
    logic              filled;
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] hit_count;
    logic [STAT_W-1:0] miss_count;
    logic [STAT_W-1:0] mem_access_count;
    logic [DIRTY_W-1:0] dirty_lines;
  } access_result_t;
endpackage

>>> sim/tb_set_assoc_lru_writeback_cache.sv
// Self-checking testbench of the set-associative LRU write-back cache.
`timescale 1ns / 1ps
module tb_set_assoc_lru_writeback_cache;
  import salc_pkg::*;
  import tb_salc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  salc_req_if req();
  salc_rsp_if rsp();

  set_assoc_lru_writeback_cache DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // shadow cache state
  logic              sh_valid [NUM_LINES];
  logic              sh_dirty [NUM_LINES];
  logic [TAG_W-1:0]  sh_tag   [NUM_LINES];
  logic [WAY_W:0]    sh_rank  [NUM_LINES];
  logic [DATA_W-1:0] sh_words [DATA_DEPTH];
  logic [DATA_W-1:0] sh_mem   [BACK_DEPTH];
  logic [STAT_W-1:0] sh_hits, sh_misses, sh_mem_acc;
  logic [DIRTY_W-1:0] sh_dirty_total;

  access_result_t expected_results[$];
  int errors = 0;
  bit long_stall = 1'b0;

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_LINES; i++) begin
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_tag[i] = '0;
      sh_rank[i] = '0;
    end
    for (int i = 0; i < DATA_DEPTH; i++) sh_words[i] = '0;
    for (int i = 0; i < BACK_DEPTH; i++) sh_mem[i] = '0;
    sh_hits = '0;
    sh_misses = '0;
    sh_mem_acc = '0;
    sh_dirty_total = '0;
  endfunction

  function automatic logic [STAT_W-1:0] bump(input logic [STAT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // advance the shadow cache by one access and return what the block should report
  function automatic access_result_t predict_access(input logic is_wr,
      input logic [ADDR_BITS-1:0] a, input logic [DATA_W-1:0] wd);
    access_result_t r;
    int word, lineno, offs, set_i, base, way, free_way, ln, best, old_rank, vline;
    logic [TAG_W-1:0] tg;
    r = '0;
    word = a >> 2;
    lineno = word / WORDS_PER_LINE;
    offs = word % WORDS_PER_LINE;
    set_i = lineno % NUM_SETS;
    tg = TAG_W'(lineno / NUM_SETS);
    base = set_i * NUM_WAYS;
    way = NUM_WAYS;
    free_way = NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way == NUM_WAYS) begin
        if (sh_valid[base+w] && sh_tag[base+w] == tg) way = w;
        else if (!sh_valid[base+w] && free_way == NUM_WAYS) free_way = w;
      end
    end
    if (way < NUM_WAYS) begin
      r.hit = 1'b1;
      sh_hits = bump(sh_hits);
    end else begin
      sh_misses = bump(sh_misses);
      if (free_way < NUM_WAYS) way = free_way;
      else begin
        best = 0;
        way = 0;
        for (int w = 0; w < NUM_WAYS; w++)
          if (sh_rank[base+w] > best) begin
            best = sh_rank[base+w];
            way = w;
          end
        ln = base + way;
        if (sh_dirty[ln]) begin
          vline = sh_tag[ln] * NUM_SETS + set_i;
          for (int i = 0; i < WORDS_PER_LINE; i++)
            if (vline * WORDS_PER_LINE + i < BACK_DEPTH)
              sh_mem[vline*WORDS_PER_LINE+i] = sh_words[ln*WORDS_PER_LINE+i];
          r.wrote_back = 1'b1;
          sh_mem_acc = bump(sh_mem_acc);
          sh_dirty[ln] = 1'b0;
          if (sh_dirty_total > 0) sh_dirty_total--;
        end
      end
      ln = base + way;
      if (!is_wr || WORDS_PER_LINE != 1) begin
        for (int i = 0; i < WORDS_PER_LINE; i++)
          sh_words[ln*WORDS_PER_LINE+i] = (lineno*WORDS_PER_LINE + i < BACK_DEPTH) ?
              sh_mem[lineno*WORDS_PER_LINE+i] : '0;
        r.filled = 1'b1;
        sh_mem_acc = bump(sh_mem_acc);
      end
      sh_tag[ln] = tg;
    end
    ln = base + way;
    // promote the touched way to most recent
    old_rank = sh_valid[ln] ? sh_rank[ln] : NUM_WAYS;
    for (int v = 0; v < NUM_WAYS; v++)
      if (v != way && sh_valid[base+v] && sh_rank[base+v] < old_rank &&
          sh_rank[base+v] < NUM_WAYS - 1)
        sh_rank[base+v]++;
    sh_rank[ln] = '0;
    sh_valid[ln] = 1'b1;
    if (is_wr == CMD_WRITE) begin
      sh_words[ln*WORDS_PER_LINE+offs] = wd;
      if (!sh_dirty[ln]) begin
        sh_dirty[ln] = 1'b1;
        sh_dirty_total++;
      end
    end
    r.read_data = sh_words[ln*WORDS_PER_LINE+offs];
    r.hit_count = sh_hits;
    r.miss_count = sh_misses;
    r.mem_access_count = sh_mem_acc;
    r.dirty_lines = sh_dirty_total;
    return r;
  endfunction

  // send one access; when not gapless, drop valid after the beat and idle before returning
  task automatic send_access(input logic c, input logic [ADDR_BITS-1:0] a,
      input logic [DATA_W-1:0] wd, input bit keep_gapless);
    req.valid <= 1'b1;
    req.cmd <= c;
    req.addr <= a;
    req.wr_data <= wd;
    do @(posedge clk); while (!req.ready);
    expected_results.push_back(predict_access(c, a, wd));
    @(negedge clk);
    if (!keep_gapless) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  int burst_left = 0;
  // burst pacing: random bursts with random gaps
  task automatic paced_access(input logic c, input logic [ADDR_BITS-1:0] a,
      input logic [DATA_W-1:0] wd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    send_access(c, a, wd, burst_left != 0);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (long_stall) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 7) < 5) || ($time / 40000) % 3 == 0;
  end

  // result checker
  always @(posedge clk) begin
    access_result_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.hit, rsp.wrote_back, rsp.filled, rsp.read_data, rsp.hit_count,
              rsp.miss_count, rsp.mem_access_count, rsp.dirty_lines};
      if (expected_results.size() == 0) begin
        $error("result beat with no access outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, got.hit); errors++;
        end
        if (got.wrote_back !== want.wrote_back) begin
          $error("wrote_back: expected %0d actual %0d", want.wrote_back, got.wrote_back);
          errors++;
        end
        if (got.filled !== want.filled) begin
          $error("filled: expected %0d actual %0d", want.filled, got.filled); errors++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h actual %h", want.read_data, got.read_data);
          errors++;
        end
        if (got.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d actual %0d", want.hit_count, got.hit_count);
          errors++;
        end
        if (got.miss_count !== want.miss_count) begin
          $error("miss_count: expected %0d actual %0d", want.miss_count, got.miss_count);
          errors++;
        end
        if (got.mem_access_count !== want.mem_access_count) begin
          $error("mem_access_count: expected %0d actual %0d", want.mem_access_count,
                 got.mem_access_count);
          errors++;
        end
        if (got.dirty_lines !== want.dirty_lines) begin
          $error("dirty_lines: expected %0d actual %0d", want.dirty_lines, got.dirty_lines);
          errors++;
        end
      end
    end
  end

  function automatic logic [ADDR_BITS-1:0] make_addr(input int tg, input int set_i,
      input int offs);
    return ADDR_BITS'((((tg * NUM_SETS + set_i) * WORDS_PER_LINE) + offs) * 4
                      + $urandom_range(0, 3));
  endfunction

  task automatic test_extremes();
    send_access(CMD_READ, '0, '0, 0);
    send_access(CMD_READ, '1, '1, 0);
    send_access(CMD_WRITE, '0, 32'h8000_0000, 0);
    send_access(CMD_WRITE, '1, 32'h7FFF_FFFF, 0);
    send_access(CMD_READ, 16'h0003, '0, 0);
    send_access(CMD_WRITE, 16'hFFFC, 32'hFFFF_FFFF, 0);
    send_access(CMD_READ, 16'h5555, '0, 0);
    send_access(CMD_WRITE, 16'hAAAA, 32'h5555_AAAA, 0);
  endtask

  // fill a set past its ways: evictions, dirty writebacks, refill of written data
  task automatic test_evictions();
    for (int t = 0; t < 6; t++)
      send_access(CMD_WRITE, make_addr(t, 3, t % WORDS_PER_LINE), 32'hC0DE_0000 + t, 1);
    for (int t = 0; t < 6; t++)
      send_access(CMD_READ, make_addr(t, 3, t % WORDS_PER_LINE), '0, t != 5);
    // clean reads then an eviction without writeback in another set
    for (int t = 0; t < 5; t++)
      send_access(CMD_READ, make_addr(t + 10, 7, 0), '0, t != 4);
  endtask

  task automatic test_random(input int n);
    int r, tg, set_i;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      // mostly a small working set per set so that hits, LRU and evictions all occur
      tg = (r < 8) ? $urandom_range(0, 6) : $urandom_range(0, (1 << TAG_W) - 1);
      set_i = (r < 7) ? $urandom_range(0, 3) : $urandom_range(0, NUM_SETS - 1);
      paced_access(logic'($urandom_range(0, 1)),
                   make_addr(tg, set_i, $urandom_range(0, WORDS_PER_LINE - 1)),
                   $urandom());
    end
    req.valid <= 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_stall = 1'b1;
        repeat (300) @(negedge clk);
        long_stall = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_access(logic'($urandom_range(0, 1)), ADDR_BITS'($urandom()), $urandom(),
                    i != 19);
    join
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_READ;
    req.addr = '0;
    req.wr_data = '0;
    rsp.ready = 1'b0;
    shadow_reset();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_evictions();
    test_backpressure();
    test_random(1200);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("status: fail");
    $finish;
  end
endmodule
